### src/text_console_cell_writer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text console cell writer.
// Each check is compiled only for simulation; synthesis sees an empty body.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication check.
`define TCCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tccw check failed");
// Next-cycle implication check.
`define TCCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tccw check failed");
`else
`define TCCW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TCCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### src/tccw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  // Field widths.
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int POS_W   = 8;
  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int COLOR_W = 4;
  localparam int ADDR_W  = 11;
  localparam int WORD_W  = 16;
  localparam int PROD_W  = 2 * POS_W;

  // Configuration port.
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // Reset values.
  localparam logic [ROW_W-1:0]   CURSOR_ROW_RST = ROW_W'(19);
  localparam logic [COLOR_W-1:0] FG_RST         = COLOR_W'(2);
  localparam logic [COLOR_W-1:0] BG_RST         = COLOR_W'(0);

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Item operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_PUT    = 2'd0,
    OP_SET    = 2'd1,
    OP_PUT_AT = 2'd2
  } op_t;

  // Register index codes.
  typedef enum logic {
    REG_FG = 1'b0,
    REG_BG = 1'b1
  } reg_idx_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic              cell_write;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic              debug_valid;
    logic [CHAR_W-1:0] char_code;
    logic              status;
  } cmd_t;

endpackage

### src/tccw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_front
// Accepts items, keeps the cursor and classifies each item into a command.
// ----------------------------------------------------------------------------
module tccw_front import tccw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  logic              q_full_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [POS_W-1:0]  pos_x_i,
  input  logic [POS_W-1:0]  pos_y_i,
  output logic              q_push_o,
  output cmd_t              cmd_o
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             accept;
  logic             pos_ok;
  logic             is_nl;
  logic [ROW_W-1:0] row_inc;
  logic [COL_W-1:0] col_inc;
  op_t              op;

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;
  assign op       = op_t'(op_i);
  assign pos_ok   = (pos_x_i < POS_W'(COLUMNS)) && (pos_y_i < POS_W'(ROWS));
  assign is_nl    = (char_code_i == NEWLINE_CODE);
  assign row_inc  = (row_r == ROW_W'(ROWS - 1)) ? '0 : row_r + 1'b1;
  assign col_inc  = col_r + 1'b1;

  // Classify the item and work out the next cursor.
  always_comb begin
    cmd_o   = '0;
    col_nxt = col_r;
    row_nxt = row_r;
    unique case (op)
      OP_PUT: begin
        cmd_o.debug_valid = 1'b1;
        cmd_o.char_code   = char_code_i;
        if (is_nl) begin
          col_nxt = '0;
          row_nxt = row_inc;
        end else begin
          cmd_o.cell_write = 1'b1;
          cmd_o.col        = POS_W'(col_r);
          cmd_o.row        = POS_W'(row_r);
          if (col_inc >= COL_W'(COLUMNS)) begin
            col_nxt = '0;
            row_nxt = row_inc;
          end else begin
            col_nxt = col_inc;
          end
        end
      end
      OP_SET: begin
        if (pos_ok) begin
          col_nxt = COL_W'(pos_x_i);
          row_nxt = ROW_W'(pos_y_i);
        end else begin
          cmd_o.status = 1'b1;
        end
      end
      OP_PUT_AT: begin
        cmd_o.debug_valid = 1'b1;
        cmd_o.char_code   = char_code_i;
        if (!pos_ok) begin
          cmd_o.status = 1'b1;
        end else if (!is_nl) begin
          cmd_o.cell_write = 1'b1;
          cmd_o.col        = pos_x_i;
          cmd_o.row        = pos_y_i;
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // Cursor registers move only on an accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= CURSOR_ROW_RST;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### src/tccw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module tccw_fifo import tccw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_push, do_pop;

  assign full_o  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_r[rd_ptr_r];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### src/tccw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_back
// Turns a queued command into a result item held in the output register.
// ----------------------------------------------------------------------------
module tccw_back import tccw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty_i,
  input  cmd_t               cmd_i,
  output logic               q_pop_o,
  input  logic [COLOR_W-1:0] fg_i,
  input  logic [COLOR_W-1:0] bg_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic               cell_write_o,
  output logic [ADDR_W-1:0]  cell_address_o,
  output logic [WORD_W-1:0]  cell_word_o,
  output logic               debug_valid_o,
  output logic [CHAR_W-1:0]  debug_char_o,
  output logic               status_o
);

  logic              valid_r;
  logic              take;
  logic [PROD_W-1:0] addr_full;
  logic [WORD_W-1:0] word_nxt;

  assign empty_o = !valid_r;
  // Load a new result when the register is free or being emptied.
  assign take    = !q_empty_i && (!valid_r || pop_i);
  assign q_pop_o = take;

  // Cell index: row times columns plus column, kept to the address width.
  assign addr_full = PROD_W'(cmd_i.row) * PROD_W'(COLUMNS) + PROD_W'(cmd_i.col);
  assign word_nxt  = cmd_i.cell_write ? {bg_i, fg_i, cmd_i.char_code} : '0;

  // Output register holding the oldest result item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (pop_i) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cell_write_o   <= cmd_i.cell_write;
      cell_address_o <= addr_full[ADDR_W-1:0];
      cell_word_o    <= word_nxt;
      debug_valid_o  <= cmd_i.debug_valid;
      debug_char_o   <= cmd_i.char_code;
      status_o       <= cmd_i.status;
    end
  end

endmodule

### src/text_console_cell_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text console writer: cursor tracking and screen cell write generation.
// ----------------------------------------------------------------------------
// Channel   | Handshake              | Payload
// input     | push / full            | in_op, in_char_code, in_pos_x, in_pos_y
// result    | empty / pop            | out_cell_write .. out_status
// config    | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// One item per cycle is sustained while full is low; an item passes through
// the queue, then the output register. The front's registered cursor update
// is the loop that sets the rate. A four-entry queue plus the output register
// absorb result-side stalls; full rises only when both are occupied.
// Reset (rst_n, synchronous) empties the queue and output register, puts the
// cursor at column 0 row 19 and the colors at foreground 2, background 0.
// ----------------------------------------------------------------------------
`include "text_console_cell_writer_macros.svh"

module text_console_cell_writer import tccw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // Input items
  input  logic               push,
  output logic               full,
  input  logic [OP_W-1:0]    in_op,
  input  logic [CHAR_W-1:0]  in_char_code,
  input  logic [POS_W-1:0]   in_pos_x,
  input  logic [POS_W-1:0]   in_pos_y,
  // Result items
  output logic               empty,
  input  logic               pop,
  output logic               out_cell_write,
  output logic [ADDR_W-1:0]  out_cell_address,
  output logic [WORD_W-1:0]  out_cell_word,
  output logic               out_debug_valid,
  output logic [CHAR_W-1:0]  out_debug_char,
  output logic               out_status,
  // Configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  logic [COLOR_W-1:0] fg_r, bg_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic               q_push, q_full, q_pop, q_empty;
  cmd_t               front_cmd, q_cmd;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RST;
      bg_r <= BG_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FG: fg_r <= pwdata[COLOR_W-1:0];
        REG_BG: bg_r <= pwdata[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      REG_FG:  prdata = CFG_DW'(fg_r);
      REG_BG:  prdata = CFG_DW'(bg_r);
      default: prdata = '0;
    endcase
  end

  assign full = q_full;

  tccw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .q_full_i    (q_full),
    .op_i        (in_op),
    .char_code_i (in_char_code),
    .pos_x_i     (in_pos_x),
    .pos_y_i     (in_pos_y),
    .q_push_o    (q_push),
    .cmd_o       (front_cmd)
  );

  tccw_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_cmd),
    .empty_o (q_empty)
  );

  tccw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty_i      (q_empty),
    .cmd_i          (q_cmd),
    .q_pop_o        (q_pop),
    .fg_i           (fg_r),
    .bg_i           (bg_r),
    .pop_i          (pop),
    .empty_o        (empty),
    .cell_write_o   (out_cell_write),
    .cell_address_o (out_cell_address),
    .cell_word_o    (out_cell_word),
    .debug_valid_o  (out_debug_valid),
    .debug_char_o   (out_debug_char),
    .status_o       (out_status)
  );

  // A written cell always lies on the screen and is always echoed.
  `TCCW_ASSERT_IMPL(a_cell_on_screen, clk, rst_n, !empty && out_cell_write, out_debug_valid && (out_cell_address < ADDR_W'(COLUMNS * ROWS)))
  // An error result never carries a cell write or an address.
  `TCCW_ASSERT_IMPL(a_status_no_write, clk, rst_n, !empty && out_status, !out_cell_write && (out_cell_address == '0))
  // A foreground write lands in the register on the next cycle.
  `TCCW_ASSERT_NEXT(a_fg_write, clk, rst_n, cfg_wr && (cfg_idx == REG_FG), fg_r == $past(pwdata[COLOR_W-1:0]))

endmodule

### dv/cell_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_write_checker
// Watches the item and result channels of the console cell writer, tracks the
// cursor and colors on its own, and compares every result with the oldest
// predicted cell write. Reports the number of mismatches to the testbench top.
// ----------------------------------------------------------------------------
module cell_write_checker import tccw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              full,
  input  logic [OP_W-1:0]   in_op,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [POS_W-1:0]  in_pos_x,
  input  logic [POS_W-1:0]  in_pos_y,
  input  logic              empty,
  input  logic              pop,
  input  logic              out_cell_write,
  input  logic [ADDR_W-1:0] out_cell_address,
  input  logic [WORD_W-1:0] out_cell_word,
  input  logic              out_debug_valid,
  input  logic [CHAR_W-1:0] out_debug_char,
  input  logic              out_status,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output int                mismatch_count,
  output int                cells_pending
);

  localparam logic [CFG_AW-1:0] FG_ADDR = CFG_AW'(4 * int'(REG_FG));
  localparam logic [CFG_AW-1:0] BG_ADDR = CFG_AW'(4 * int'(REG_BG));
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic              cell_write;
    logic [ADDR_W-1:0] cell_address;
    logic [WORD_W-1:0] cell_word;
    logic              debug_valid;
    logic [CHAR_W-1:0] debug_char;
    logic              status;
  } cell_result_t;

  logic [COL_W-1:0]   cursor_x;
  logic [ROW_W-1:0]   cursor_y;
  logic [COLOR_W-1:0] fg_shadow;
  logic [COLOR_W-1:0] bg_shadow;
  cell_result_t       expected_cells[$];
  int                 mismatches = 0;
  int                 pending = 0;

  assign mismatch_count = mismatches;
  assign cells_pending  = pending;

  function automatic logic on_screen(logic [POS_W-1:0] x, logic [POS_W-1:0] y);
    return (int'(x) < COLUMNS) && (int'(y) < ROWS);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_index(int col, int row);
    return ADDR_W'(row * COLUMNS + col);
  endfunction

  // The row wraps to the top; the screen never scrolls.
  function automatic void next_row();
    cursor_y = ROW_W'((int'(cursor_y) + 1) % ROWS);
  endfunction

  // Computes the result of one item and moves the cursor as the block does.
  function automatic cell_result_t predict_cell(logic [OP_W-1:0] op,
                                                logic [CHAR_W-1:0] ch,
                                                logic [POS_W-1:0] x,
                                                logic [POS_W-1:0] y);
    cell_result_t r;
    r = '0;
    case (op)
      OP_PUT: begin
        r.debug_valid = 1'b1;
        r.debug_char  = ch;
        if (ch == NEWLINE_CODE) begin
          cursor_x = '0;
          next_row();
        end else begin
          r.cell_write   = 1'b1;
          r.cell_address = cell_index(int'(cursor_x), int'(cursor_y));
          r.cell_word    = {bg_shadow, fg_shadow, ch};
          if (int'(cursor_x) + 1 >= COLUMNS) begin
            cursor_x = '0;
            next_row();
          end else begin
            cursor_x = cursor_x + 1'b1;
          end
        end
      end
      OP_SET: begin
        if (on_screen(x, y)) begin
          cursor_x = COL_W'(x);
          cursor_y = ROW_W'(y);
        end else begin
          r.status = 1'b1;
        end
      end
      OP_PUT_AT: begin
        r.debug_valid = 1'b1;
        r.debug_char  = ch;
        if (!on_screen(x, y)) begin
          r.status = 1'b1;
        end else if (ch != NEWLINE_CODE) begin
          r.cell_write   = 1'b1;
          r.cell_address = cell_index(int'(x), int'(y));
          r.cell_word    = {bg_shadow, fg_shadow, ch};
        end
      end
      default: begin
        // The undefined operation leaves the cursor alone and yields an all-zero result.
      end
    endcase
    return r;
  endfunction

  // Sample both channels and the register port at each rising edge.
  always @(posedge clk) begin
    cell_result_t got;
    cell_result_t want;
    if (!rst_n) begin
      cursor_x  = '0;
      cursor_y  = CURSOR_ROW_RST;
      fg_shadow = FG_RST;
      bg_shadow = BG_RST;
      expected_cells.delete();
    end else begin
      // Compare an accepted result with the oldest prediction.
      if (pop && !empty) begin
        got = '{out_cell_write, out_cell_address, out_cell_word,
                out_debug_valid, out_debug_char, out_status};
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("cell result with no item waiting: wr=%0d addr=%0d word=%h dv=%0d dch=%h st=%0d",
                     got.cell_write, got.cell_address, got.cell_word,
                     got.debug_valid, got.debug_char, got.status);
        end else begin
          want = expected_cells.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("cell result mismatch: expected wr=%0d addr=%0d word=%h dv=%0d dch=%h st=%0d, got wr=%0d addr=%0d word=%h dv=%0d dch=%h st=%0d",
                       want.cell_write, want.cell_address, want.cell_word,
                       want.debug_valid, want.debug_char, want.status,
                       got.cell_write, got.cell_address, got.cell_word,
                       got.debug_valid, got.debug_char, got.status);
          end
        end
      end
      // Every accepted item causes exactly one result.
      if (push && !full)
        expected_cells.push_back(predict_cell(in_op, in_char_code, in_pos_x, in_pos_y));
      // Follow color register writes.
      if (psel && penable && pwrite && pready) begin
        if (paddr == FG_ADDR)
          fg_shadow = pwdata[COLOR_W-1:0];
        else if (paddr == BG_ADDR)
          bg_shadow = pwdata[COLOR_W-1:0];
      end
    end
    pending = expected_cells.size();
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the console cell writer with directed and random items under several
// color settings and idling patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  import tccw_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 260;
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [OP_W-1:0]   in_op = '0;
  logic [CHAR_W-1:0] in_char_code = '0;
  logic [POS_W-1:0]  in_pos_x = '0;
  logic [POS_W-1:0]  in_pos_y = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic              out_cell_write;
  logic [ADDR_W-1:0] out_cell_address;
  logic [WORD_W-1:0] out_cell_word;
  logic              out_debug_valid;
  logic [CHAR_W-1:0] out_debug_char;
  logic              out_status;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int items_taken = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int pop_stall_pct = 0;
  int mismatch_count;
  int cells_pending;

  always #(CLK_PERIOD / 2) clk = ~clk;

  text_console_cell_writer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_op            (in_op),
    .in_char_code     (in_char_code),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .empty            (empty),
    .pop              (pop),
    .out_cell_write   (out_cell_write),
    .out_cell_address (out_cell_address),
    .out_cell_word    (out_cell_word),
    .out_debug_valid  (out_debug_valid),
    .out_debug_char   (out_debug_char),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  cell_write_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_op            (in_op),
    .in_char_code     (in_char_code),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .empty            (empty),
    .pop              (pop),
    .out_cell_write   (out_cell_write),
    .out_cell_address (out_cell_address),
    .out_cell_word    (out_cell_word),
    .out_debug_valid  (out_debug_valid),
    .out_debug_char   (out_debug_char),
    .out_status       (out_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .mismatch_count   (mismatch_count),
    .cells_pending    (cells_pending)
  );

  // Count accepted items so the sender can tell when its item was taken.
  always @(posedge clk) begin
    if (rst_n && push && !full)
      items_taken <= items_taken + 1;
  end

  // Guard against a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    pop <= rst_n && ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // Offers one item, possibly after some idle cycles, and waits until it is taken.
  task automatic send_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                           logic [POS_W-1:0] x, logic [POS_W-1:0] y);
    int taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push         <= 1'b1;
    in_op        <= op;
    in_char_code <= ch;
    in_pos_x     <= x;
    in_pos_y     <= y;
    taken = items_taken;
    do @(negedge clk); while (items_taken == taken);
  endtask

  // Mostly on-screen positions, with a share of arbitrary ones.
  task automatic send_random_item(inout int counted);
    int pick;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    pick = $urandom_range(0, 99);
    ch = ($urandom_range(0, 9) == 0) ? NEWLINE_CODE : CHAR_W'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) begin
      x = POS_W'($urandom_range(0, 255));
      y = POS_W'($urandom_range(0, 255));
    end else begin
      x = POS_W'($urandom_range(0, COLUMNS - 1));
      y = POS_W'($urandom_range(0, ROWS - 1));
    end
    if (pick < 55)
      op = OP_PUT;
    else if (pick < 70)
      op = OP_SET;
    else if (pick < 96)
      op = OP_PUT_AT;
    else
      op = OP_UNDEF;
    send_item(op, ch, x, y);
    counted++;
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(reg_idx_t idx, logic [COLOR_W-1:0] value);
    logic ready;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CFG_AW'(4 * int'(idx));
    pwdata  <= CFG_DW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do begin
      ready = pready;
      @(negedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic wait_idle();
    push <= 1'b0;
    while (cells_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    int counted;
    int phase;
    logic [COLOR_W-1:0] fg_val;
    logic [COLOR_W-1:0] bg_val;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Directed items with the reset colors, starting from the reset cursor.
    send_item(OP_PUT, 8'h41, 8'd0, 8'd0);
    send_item(OP_PUT, 8'h00, 8'd255, 8'd255);
    send_item(OP_PUT, 8'hFF, 8'd0, 8'd0);
    send_item(OP_PUT, NEWLINE_CODE, 8'd0, 8'd0);
    // Last cell of the screen, then wrap of both column and row.
    send_item(OP_SET, 8'h00, 8'd79, 8'd24);
    send_item(OP_PUT, 8'h7E, 8'd0, 8'd0);
    send_item(OP_PUT, 8'h20, 8'd0, 8'd0);
    // A newline on the bottom row wraps to the top.
    send_item(OP_SET, 8'h00, 8'd0, 8'd24);
    send_item(OP_PUT, NEWLINE_CODE, 8'd0, 8'd0);
    // Set cursor out of range.
    send_item(OP_SET, 8'h00, 8'd80, 8'd24);
    send_item(OP_SET, 8'h00, 8'd79, 8'd25);
    send_item(OP_SET, 8'hFF, 8'd255, 8'd255);
    send_item(OP_SET, 8'h00, 8'd0, 8'd0);
    // Put at position, in and out of range, and with a newline.
    send_item(OP_PUT_AT, 8'hAA, 8'd0, 8'd0);
    send_item(OP_PUT_AT, 8'h55, 8'd79, 8'd24);
    send_item(OP_PUT_AT, 8'h31, 8'd80, 8'd0);
    send_item(OP_PUT_AT, 8'h32, 8'd0, 8'd25);
    send_item(OP_PUT_AT, 8'hFF, 8'd255, 8'd255);
    send_item(OP_PUT_AT, NEWLINE_CODE, 8'd10, 8'd5);
    send_item(OP_PUT_AT, NEWLINE_CODE, 8'd200, 8'd3);
    // The undefined operation, then a put proving the cursor did not move.
    send_item(OP_UNDEF, 8'hFF, 8'd255, 8'd255);
    send_item(OP_PUT, 8'h42, 8'd0, 8'd0);
    wait_idle();

    // Random phases, each with its own colors and idling pattern.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          fg_val = 4'h0;
          bg_val = 4'h0;
        end
        1: begin
          fg_val = 4'hF;
          bg_val = 4'hF;
        end
        2: begin
          fg_val = 4'hF;
          bg_val = 4'h0;
        end
        3: begin
          fg_val = 4'h0;
          bg_val = 4'hF;
        end
        default: begin
          fg_val = COLOR_W'($urandom_range(0, 15));
          bg_val = COLOR_W'($urandom_range(0, 15));
        end
      endcase
      cfg_write(REG_FG, fg_val);
      cfg_write(REG_BG, bg_val);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 56;
          pop_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 56;
        end
        default: begin
          send_idle_pct = 8;
          pop_stall_pct = 8;
        end
      endcase
      counted = 0;
      while (counted < PHASE_ITEMS) send_random_item(counted);
      wait_idle();
    end

    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/tccw_pkg.sv
src/tccw_front.sv
src/tccw_fifo.sv
src/tccw_back.sv
src/text_console_cell_writer.sv
dv/cell_write_checker.sv
dv/tb_top.sv
